>>> rtl/core/aabb_collision_response_defines.svh
`ifndef AABB_COLLISION_RESPONSE_DEFINES_SVH
`define AABB_COLLISION_RESPONSE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ACR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ACR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/acr_pkg.sv
package acr_pkg;

  localparam int TIME_FRAC  = 16;
  localparam int FRAME_BITS = 24;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [FRAME_BITS-1:0] FRAME_RESET = 24'd1092;

  // register index taken from the word address
  localparam logic REG_FRAME_TIME = 1'b0;

  localparam int FLAG_FLOOR   = 0;
  localparam int FLAG_CEILING = 1;
  localparam int FLAG_RIGHT   = 2;
  localparam int FLAG_LEFT    = 3;

  typedef enum logic [1:0] {
    AXIS_NONE,
    AXIS_VERT,
    AXIS_HORZ
  } axis_t;

endpackage

>>> rtl/core/aabb_collision_response.sv
// throughput: one box pair per cycle while the output is not stalled, set by the two pipelined restoring dividers,
//   one quotient bit per stage (COORD_BITS + 15 stages)
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset: synchronous active-low rst_n clears all valid bits and sets frame_time to 1092
module aabb_collision_response
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // own_left, own_top, own_width, own_height, own_vx, own_vy,
  // other_left, other_top, other_width, other_height, other_vx, other_vy
  input  logic [((12*COORD_BITS-4+7)/8)*8-1:0] in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // new_left, new_top, contact_flags, overlapped
  output logic [((2*COORD_BITS+5+7)/8)*8-1:0]  out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [CFG_AW-1:0]          cfg_paddr,
  input  logic [CFG_DW-1:0]          cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  localparam int C    = COORD_BITS;
  localparam int QW   = C - 1 + TIME_FRAC;
  localparam int PW   = FRAME_BITS + C + 2;
  localparam int RW   = PW + 2;
  localparam int OW   = ((2*C+5+7)/8)*8;

  localparam int OFF_OL  = 0;
  localparam int OFF_OT  = OFF_OL + C;
  localparam int OFF_OW  = OFF_OT + C;
  localparam int OFF_OH  = OFF_OW + C - 1;
  localparam int OFF_OVX = OFF_OH + C - 1;
  localparam int OFF_OVY = OFF_OVX + C;
  localparam int OFF_XL  = OFF_OVY + C;
  localparam int OFF_XT  = OFF_XL + C;
  localparam int OFF_XW  = OFF_XT + C;
  localparam int OFF_XH  = OFF_XW + C - 1;
  localparam int OFF_XVX = OFF_XH + C - 1;
  localparam int OFF_XVY = OFF_XVX + C;

  typedef struct packed {
    logic [C-1:0] ol;
    logic [C-1:0] ot;
    logic [C:0]   dvx;
    logic [C:0]   dvy;
    logic         ov;
    logic         zx;
    logic         zy;
    logic         eq_top;
    logic         eq_bot;
    logic         eq_left;
    logic         eq_right;
  } pay_t;

  typedef struct packed {
    logic [C:0]    rem_x;
    logic [C:0]    rem_y;
    logic [QW-1:0] n_x;
    logic [QW-1:0] n_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic [C:0]    d_x;
    logic [C:0]    d_y;
  } div_t;

  logic en;

  // ---------------------------------------------------------------- config
  logic [FRAME_BITS-1:0] frame_time_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r <= FRAME_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_FRAME_TIME) begin
      frame_time_r <= cfg_pwdata[FRAME_BITS-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_FRAME_TIME) begin
      cfg_prdata[FRAME_BITS-1:0] = frame_time_r;
    end
  end

  // ---------------------------------------------------------------- stage 1: overlap
  logic signed [C-1:0] ol, ot, ovx, ovy, xl, xt, xvx, xvy;
  logic [C-2:0]        ow, oh, xw, xh;
  logic signed [C:0]   o_r, o_b, x_r, x_b, ir, ib;
  logic signed [C-1:0] il, it;
  logic signed [C+1:0] iw_f, ih_f;
  logic [C-2:0]        iw, ih;
  pay_t                s1_nxt, s1_r;
  logic [C-2:0]        s1_iw_r, s1_ih_r;
  logic                s1_v_r;

  always_comb begin
    ol  = $signed(in_tdata[OFF_OL +: C]);
    ot  = $signed(in_tdata[OFF_OT +: C]);
    ow  = in_tdata[OFF_OW +: C-1];
    oh  = in_tdata[OFF_OH +: C-1];
    ovx = $signed(in_tdata[OFF_OVX +: C]);
    ovy = $signed(in_tdata[OFF_OVY +: C]);
    xl  = $signed(in_tdata[OFF_XL +: C]);
    xt  = $signed(in_tdata[OFF_XT +: C]);
    xw  = in_tdata[OFF_XW +: C-1];
    xh  = in_tdata[OFF_XH +: C-1];
    xvx = $signed(in_tdata[OFF_XVX +: C]);
    xvy = $signed(in_tdata[OFF_XVY +: C]);

    o_r = $signed({ol[C-1], ol}) + $signed({2'b00, ow});
    o_b = $signed({ot[C-1], ot}) + $signed({2'b00, oh});
    x_r = $signed({xl[C-1], xl}) + $signed({2'b00, xw});
    x_b = $signed({xt[C-1], xt}) + $signed({2'b00, xh});

    il = (ol > xl) ? ol : xl;
    it = (ot > xt) ? ot : xt;
    ir = (o_r < x_r) ? o_r : x_r;
    ib = (o_b < x_b) ? o_b : x_b;

    iw_f = $signed({ir[C], ir}) - $signed({{2{il[C-1]}}, il});
    ih_f = $signed({ib[C], ib}) - $signed({{2{it[C-1]}}, it});
    iw   = (iw_f > 0) ? iw_f[C-2:0] : '0;
    ih   = (ih_f > 0) ? ih_f[C-2:0] : '0;

    s1_nxt.ol       = ol;
    s1_nxt.ot       = ot;
    s1_nxt.dvx      = $signed({ovx[C-1], ovx}) - $signed({xvx[C-1], xvx});
    s1_nxt.dvy      = $signed({ovy[C-1], ovy}) - $signed({xvy[C-1], xvy});
    s1_nxt.ov       = (iw != '0) && (ih != '0);
    s1_nxt.zx       = 1'b0;
    s1_nxt.zy       = 1'b0;
    s1_nxt.eq_top   = (it == xt);
    s1_nxt.eq_bot   = (ib == x_b);
    s1_nxt.eq_left  = (il == xl);
    s1_nxt.eq_right = (ir == x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= s1_nxt;
      s1_iw_r <= iw;
      s1_ih_r <= ih;
    end
  end

  // ---------------------------------------------------------------- stage 2: divider setup
  pay_t pay_r [0:QW];
  div_t div_r [0:QW];
  logic v_r   [0:QW];
  pay_t s2_pay;
  div_t s2_div;

  always_comb begin
    s2_pay     = s1_r;
    s2_pay.zx  = (s1_r.dvx == '0);
    s2_pay.zy  = (s1_r.dvy == '0);
    s2_div.rem_x = '0;
    s2_div.rem_y = '0;
    s2_div.n_x   = {s1_iw_r, {TIME_FRAC{1'b0}}};
    s2_div.n_y   = {s1_ih_r, {TIME_FRAC{1'b0}}};
    s2_div.q_x   = '0;
    s2_div.q_y   = '0;
    // two's complement magnitude, C+1 bits hold 2**C
    s2_div.d_x   = s1_r.dvx[C] ? (~s1_r.dvx + 1'b1) : s1_r.dvx;
    s2_div.d_y   = s1_r.dvy[C] ? (~s1_r.dvy + 1'b1) : s1_r.dvy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= s2_pay;
      div_r[0] <= s2_div;
    end
  end

  // ---------------------------------------------------------------- restoring divider stages
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [C+1:0] trial_x, trial_y, diff_x, diff_y;
    logic         ge_x, ge_y;
    div_t         nxt;

    always_comb begin
      trial_x = {div_r[k].rem_x, div_r[k].n_x[QW-1]};
      trial_y = {div_r[k].rem_y, div_r[k].n_y[QW-1]};
      diff_x  = trial_x - {1'b0, div_r[k].d_x};
      diff_y  = trial_y - {1'b0, div_r[k].d_y};
      ge_x    = (trial_x >= {1'b0, div_r[k].d_x});
      ge_y    = (trial_y >= {1'b0, div_r[k].d_y});
      nxt       = div_r[k];
      nxt.rem_x = ge_x ? diff_x[C:0] : trial_x[C:0];
      nxt.rem_y = ge_y ? diff_y[C:0] : trial_y[C:0];
      nxt.n_x   = {div_r[k].n_x[QW-2:0], 1'b0};
      nxt.n_y   = {div_r[k].n_y[QW-2:0], 1'b0};
      nxt.q_x   = {div_r[k].q_x[QW-2:0], ge_x};
      nxt.q_y   = {div_r[k].q_y[QW-2:0], ge_y};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pay_r[k+1] <= pay_r[k];
        div_r[k+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------- axis select
  pay_t          sel_pay_r;
  logic [QW-1:0] sel_t_r, sel_t_nxt;
  axis_t         sel_axis_r, sel_axis_nxt;
  logic          sel_v_r;
  logic [QW-1:0] tx, ty;

  always_comb begin
    tx = div_r[QW].q_x;
    ty = div_r[QW].q_y;
    sel_t_nxt    = '0;
    sel_axis_nxt = AXIS_NONE;
    if (pay_r[QW].ov) begin
      priority if (!pay_r[QW].zx && !pay_r[QW].zy) begin
        sel_t_nxt    = (tx < ty) ? tx : ty;
        sel_axis_nxt = (tx > ty) ? AXIS_VERT : AXIS_HORZ;
      end else if (!pay_r[QW].zx) begin
        sel_t_nxt    = tx;
        sel_axis_nxt = AXIS_HORZ;
      end else if (!pay_r[QW].zy) begin
        sel_t_nxt    = ty;
        sel_axis_nxt = AXIS_VERT;
      end else begin
        sel_t_nxt    = '0;
        sel_axis_nxt = AXIS_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
    end else if (en) begin
      sel_v_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_pay_r  <= pay_r[QW];
      sel_t_r    <= sel_t_nxt;
      sel_axis_r <= sel_axis_nxt;
    end
  end

  // ---------------------------------------------------------------- clamp and flags
  pay_t                  clp_pay_r;
  logic [FRAME_BITS-1:0] clp_t_r, clp_t_nxt;
  logic [3:0]            clp_flags_r, clp_flags_nxt;
  logic                  clp_v_r;

  always_comb begin
    clp_t_nxt = (sel_t_r > QW'(frame_time_r)) ? frame_time_r : sel_t_r[FRAME_BITS-1:0];
    clp_flags_nxt = '0;
    unique case (sel_axis_r)
      AXIS_VERT: begin
        if (sel_pay_r.eq_top) begin
          clp_flags_nxt[FLAG_FLOOR] = 1'b1;
        end else if (sel_pay_r.eq_bot) begin
          clp_flags_nxt[FLAG_CEILING] = 1'b1;
        end
      end
      AXIS_HORZ: begin
        if (sel_pay_r.eq_left) begin
          clp_flags_nxt[FLAG_RIGHT] = 1'b1;
        end else if (sel_pay_r.eq_right) begin
          clp_flags_nxt[FLAG_LEFT] = 1'b1;
        end
      end
      default: begin
        clp_flags_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clp_v_r <= 1'b0;
    end else if (en) begin
      clp_v_r <= sel_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clp_pay_r   <= sel_pay_r;
      clp_t_r     <= clp_t_nxt;
      clp_flags_r <= clp_flags_nxt;
    end
  end

  // ---------------------------------------------------------------- displacement multiply
  logic signed [PW-1:0] mul_px_r, mul_py_r, mul_px_nxt, mul_py_nxt;
  logic [C-1:0]         mul_ol_r, mul_ot_r;
  logic [3:0]           mul_flags_r;
  logic                 mul_ov_r, mul_v_r;

  always_comb begin
    mul_px_nxt = $signed({1'b0, clp_t_r}) * $signed(clp_pay_r.dvx);
    mul_py_nxt = $signed({1'b0, clp_t_r}) * $signed(clp_pay_r.dvy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r <= clp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_px_r    <= mul_px_nxt;
      mul_py_r    <= mul_py_nxt;
      mul_ol_r    <= clp_pay_r.ol;
      mul_ot_r    <= clp_pay_r.ot;
      mul_flags_r <= clp_flags_r;
      mul_ov_r    <= clp_pay_r.ov;
    end
  end

  // ---------------------------------------------------------------- round and move back
  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (TIME_FRAC-1);

  logic signed [PW:0]   rx, ry;
  logic signed [RW-1:0] rnd_nl_r, rnd_nt_r, rnd_nl_nxt, rnd_nt_nxt;
  logic [3:0]           rnd_flags_r;
  logic                 rnd_ov_r, rnd_v_r;

  always_comb begin
    // floor of (p + half) / 2**16 is an arithmetic shift
    rx = ($signed({mul_px_r[PW-1], mul_px_r}) + HALF) >>> TIME_FRAC;
    ry = ($signed({mul_py_r[PW-1], mul_py_r}) + HALF) >>> TIME_FRAC;
    rnd_nl_nxt = $signed({{(RW-C){mul_ol_r[C-1]}}, mul_ol_r}) - $signed({rx[PW], rx});
    rnd_nt_nxt = $signed({{(RW-C){mul_ot_r[C-1]}}, mul_ot_r}) - $signed({ry[PW], ry});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
    end else if (en) begin
      rnd_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_nl_r    <= rnd_nl_nxt;
      rnd_nt_r    <= rnd_nt_nxt;
      rnd_flags_r <= mul_flags_r;
      rnd_ov_r    <= mul_ov_r;
    end
  end

  // ---------------------------------------------------------------- saturate and output register
  localparam logic signed [RW-1:0] SMAX = $signed({{(RW-C+1){1'b0}}, {(C-1){1'b1}}});
  localparam logic signed [RW-1:0] SMIN = $signed({{(RW-C+1){1'b1}}, {(C-1){1'b0}}});

  logic [C-1:0]  sat_nl, sat_nt;
  logic [OW-1:0] out_tdata_r, out_tdata_nxt;
  logic          out_tvalid_r;

  always_comb begin
    priority if (rnd_nl_r > SMAX) begin
      sat_nl = SMAX[C-1:0];
    end else if (rnd_nl_r < SMIN) begin
      sat_nl = SMIN[C-1:0];
    end else begin
      sat_nl = rnd_nl_r[C-1:0];
    end
    priority if (rnd_nt_r > SMAX) begin
      sat_nt = SMAX[C-1:0];
    end else if (rnd_nt_r < SMIN) begin
      sat_nt = SMIN[C-1:0];
    end else begin
      sat_nt = rnd_nt_r[C-1:0];
    end
    out_tdata_nxt = OW'({rnd_ov_r, rnd_flags_r, sat_nt, sat_nl});
  end

  // the pipeline moves when the output register is empty or its transfer completes
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= rnd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> rtl/core/acr_checker.sv
`include "aabb_collision_response_defines.svh"

module acr_checker
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tready,
  input logic [((2*COORD_BITS+5+7)/8)*8-1:0]    out_tdata,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [CFG_DW-1:0]                      cfg_prdata
);

  localparam int FL_LO = 2*COORD_BITS;
  localparam int OV_B  = 2*COORD_BITS + 4;

  // a result held back by the sink stays put
  `ACR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output changed while stalled")

  // an empty output register never blocks the input side
  `ACR_ASSERT_IMP(a_in_ready, !out_tvalid, in_tready, "input stalled with empty output")

  // contact only comes with an overlap
  `ACR_ASSERT_IMP(a_flags_ov, out_tvalid && !out_tdata[OV_B], out_tdata[FL_LO +: 4] == 4'b0000, "contact flags without overlap")

  // at most one contact direction per result
  `ACR_ASSERT_IMP(a_flags_one, out_tvalid, $onehot0(out_tdata[FL_LO +: 4]), "several contact flags set")

  // read data never shows bits above the frame time register
  `ACR_ASSERT_IMP(a_prdata_w, 1'b1, cfg_prdata[CFG_DW-1:FRAME_BITS] == '0, "prdata upper bits set")

endmodule

bind aabb_collision_response acr_checker #(.COORD_BITS(COORD_BITS)) u_acr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_prdata (cfg_prdata)
);
